@@ hdl/tlssni_pkg.sv @@
// Shared types and constants for the TLS ClientHello SNI extractor.
// Used by the parser and the top level; depends on nothing.

package tlssni_pkg;

    // Longest host name that is copied out; longer names are cut.
    localparam int NAME_MAX_BYTES = 255;
    // Number of low bits of the segment length that are kept.
    localparam int LENGTH_BITS = 16;

    localparam logic [7:0]  CT_HANDSHAKE    = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  NAME_TYPE_HOST  = 8'h00;

    // Record header (5) + handshake header (4) + version (2) + random (32).
    localparam int HELLO_BODY_POS = 9 + 2 + 32;
    localparam logic [15:0] RANDOM_SKIP = 16'(HELLO_BODY_POS - 9);

    // Result item kinds.
    localparam logic ITEM_NAME    = 1'b0;
    localparam logic ITEM_VERDICT = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HDR,
        PH_RAND,
        PH_SID,
        PH_SIDSKIP,
        PH_CSL,
        PH_CSSKIP,
        PH_CML,
        PH_CMSKIP,
        PH_EXL,
        PH_EXH,
        PH_EXSKIP,
        PH_SN,
        PH_NAME
    } t_phase;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] name_byte;
        logic       found;
        logic [7:0] name_length;
    } t_result;

    // Up to two results caused by one accepted byte, in delivery order.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result slot0;
        t_result slot1;
    } t_push;

endpackage

@@ hdl/tlssni_if.sv @@
// Valid/ready channel interfaces for the payload bytes and the result items.
// Stand-alone; the payload widths follow the field definitions of the extractor.

interface tlssni_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_flag;
    logic [15:0] segment_length;

    modport source (output valid, output data_byte, output first_flag,
                    output segment_length, input ready);
    modport sink (input valid, input data_byte, input first_flag,
                  input segment_length, output ready);
endinterface

interface tlssni_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] name_byte;
    logic       found;
    logic [7:0] name_length;

    modport source (output valid, output item_kind, output name_byte,
                    output found, output name_length, input ready);
    modport sink (input valid, input item_kind, input name_byte,
                  input found, input name_length, output ready);
endinterface

@@ hdl/tlssni_parser.sv @@
// ClientHello parse state and the per-byte next-state and result logic.
// Depends on tlssni_pkg for the phase type, result structs and protocol constants.

module tlssni_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_first_flag,
    input  logic [15:0]         i_segment_length,
    output tlssni_pkg::t_push   o_push
);

    localparam int LB = tlssni_pkg::LENGTH_BITS;

    tlssni_pkg::t_phase r_phase, n_phase;
    logic [16:0]   r_pos, n_pos;
    logic [LB-1:0] r_slen, n_slen;
    logic [23:0]   r_acc, n_acc;
    logic [24:0]   r_hs_end, n_hs_end;
    logic [17:0]   r_exts_end, n_exts_end;
    logic [17:0]   r_ext_end, n_ext_end;
    logic [15:0]   r_skip, n_skip;
    logic [15:0]   r_nrem, n_nrem;
    logic [7:0]    r_copied, n_copied;

    // Working copy of the state, restarted at the segment start when a first byte arrives.
    tlssni_pkg::t_phase w_phase;
    logic [16:0]   w_pos;
    logic [LB-1:0] w_slen;
    logic [23:0]   w_acc;
    logic [15:0]   w_skip;
    logic [15:0]   w_nrem;
    logic [7:0]    w_copied;

    logic               cut;
    logic [17:0]        next_pos;
    logic [16:0]        slen17;
    logic [23:0]        shifted;
    logic [15:0]        v16;
    logic [15:0]        skip_dec;
    logic [24:0]        hs_sum;
    logic [17:0]        end_sum;
    logic [15:0]        emit;
    logic [7:0]         cnt_inc;
    logic [15:0]        nrem_dec;
    logic               fail;
    logic               done;
    logic [7:0]         done_len;
    logic               name_out;
    logic               do_fin;
    tlssni_pkg::t_phase fin_ph;
    logic               do_head;
    logic [17:0]        head_end;
    logic               verdict;
    tlssni_pkg::t_result res_cut, res_name, res_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tlssni_pkg::PH_IDLE;
            r_pos      <= '0;
            r_slen     <= '0;
            r_acc      <= '0;
            r_hs_end   <= '0;
            r_exts_end <= '0;
            r_ext_end  <= '0;
            r_skip     <= '0;
            r_nrem     <= '0;
            r_copied   <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_slen     <= n_slen;
            r_acc      <= n_acc;
            r_hs_end   <= n_hs_end;
            r_exts_end <= n_exts_end;
            r_ext_end  <= n_ext_end;
            r_skip     <= n_skip;
            r_nrem     <= n_nrem;
            r_copied   <= n_copied;
        end
    end

    always_comb begin
        // A first byte closes an unfinished segment and restarts the walk.
        cut = i_first_flag && (r_phase != tlssni_pkg::PH_IDLE);
        if (i_first_flag) begin
            w_phase  = tlssni_pkg::PH_HDR;
            w_pos    = '0;
            w_slen   = i_segment_length[LB-1:0];
            w_acc    = '0;
            w_skip   = '0;
            w_nrem   = '0;
            w_copied = '0;
        end else begin
            w_phase  = r_phase;
            w_pos    = r_pos;
            w_slen   = r_slen;
            w_acc    = r_acc;
            w_skip   = r_skip;
            w_nrem   = r_nrem;
            w_copied = r_copied;
        end

        n_phase    = w_phase;
        n_pos      = w_pos;
        n_slen     = w_slen;
        n_acc      = w_acc;
        n_hs_end   = r_hs_end;
        n_exts_end = r_exts_end;
        n_ext_end  = r_ext_end;
        n_skip     = w_skip;
        n_nrem     = w_nrem;
        n_copied   = w_copied;

        next_pos = {1'b0, w_pos} + 18'd1;
        slen17   = 17'(w_slen);
        shifted  = {w_acc[15:0], i_data_byte};
        v16      = shifted[15:0];
        skip_dec = (w_skip != 16'd0) ? w_skip - 16'd1 : w_skip;
        hs_sum   = 25'd9 + 25'(shifted);
        end_sum  = next_pos + 18'(v16);
        emit     = (v16 < 16'(tlssni_pkg::NAME_MAX_BYTES)) ? v16
                                                           : 16'(tlssni_pkg::NAME_MAX_BYTES);
        cnt_inc  = (w_copied != 8'hFF) ? w_copied + 8'd1 : w_copied;
        nrem_dec = (w_nrem != 16'd0) ? w_nrem - 16'd1 : w_nrem;

        fail     = 1'b0;
        done     = 1'b0;
        done_len = '0;
        name_out = 1'b0;
        do_fin   = 1'b0;
        fin_ph   = w_phase;
        do_head  = 1'b0;
        head_end = r_exts_end;

        case (w_phase)
            tlssni_pkg::PH_HDR: begin
                if (w_pos == 17'd0) begin
                    if (slen17 < 17'd5 || i_data_byte != tlssni_pkg::CT_HANDSHAKE) begin
                        fail = 1'b1;
                    end
                end else if (w_pos inside {17'd3, 17'd6}) begin
                    n_acc = {16'd0, i_data_byte};
                end else if (w_pos == 17'd4) begin
                    if ((17'd5 + 17'({w_acc[7:0], i_data_byte})) > slen17
                        || slen17 < 17'd9) begin
                        fail = 1'b1;
                    end
                end else if (w_pos == 17'd5) begin
                    if (i_data_byte != tlssni_pkg::HS_CLIENT_HELLO) begin
                        fail = 1'b1;
                    end
                end else if (w_pos == 17'd7) begin
                    n_acc = shifted;
                end else if (w_pos == 17'd8) begin
                    n_acc    = shifted;
                    n_hs_end = hs_sum;
                    if (hs_sum > 25'(w_slen)
                        || 25'(tlssni_pkg::HELLO_BODY_POS + 1) > hs_sum) begin
                        fail = 1'b1;
                    end else begin
                        n_phase = tlssni_pkg::PH_RAND;
                        n_skip  = tlssni_pkg::RANDOM_SKIP;
                    end
                end
            end
            tlssni_pkg::PH_RAND, tlssni_pkg::PH_SIDSKIP, tlssni_pkg::PH_CSSKIP,
            tlssni_pkg::PH_CMSKIP, tlssni_pkg::PH_EXSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    do_fin = 1'b1;
                    fin_ph = w_phase;
                end
            end
            tlssni_pkg::PH_SID, tlssni_pkg::PH_CSL, tlssni_pkg::PH_CML,
            tlssni_pkg::PH_EXL, tlssni_pkg::PH_EXH, tlssni_pkg::PH_SN: begin
                n_acc  = shifted;
                n_skip = skip_dec;
                // The extension type is parked in the name counter while its length arrives.
                if (w_phase == tlssni_pkg::PH_EXH && skip_dec == 16'd2) begin
                    n_nrem = v16;
                    n_acc  = '0;
                end
                if (skip_dec == 16'd0) begin
                    case (w_phase)
                        tlssni_pkg::PH_SID: begin
                            if (25'(next_pos) + 25'(v16) + 25'd2 > r_hs_end) begin
                                fail = 1'b1;
                            end else if (v16 == 16'd0) begin
                                do_fin = 1'b1;
                                fin_ph = tlssni_pkg::PH_SIDSKIP;
                            end else begin
                                n_phase = tlssni_pkg::PH_SIDSKIP;
                                n_skip  = v16;
                            end
                        end
                        tlssni_pkg::PH_CSL: begin
                            if (25'(next_pos) + 25'(v16) + 25'd1 > r_hs_end) begin
                                fail = 1'b1;
                            end else if (v16 == 16'd0) begin
                                do_fin = 1'b1;
                                fin_ph = tlssni_pkg::PH_CSSKIP;
                            end else begin
                                n_phase = tlssni_pkg::PH_CSSKIP;
                                n_skip  = v16;
                            end
                        end
                        tlssni_pkg::PH_CML: begin
                            if (25'(next_pos) + 25'(v16) + 25'd2 > r_hs_end) begin
                                fail = 1'b1;
                            end else if (v16 == 16'd0) begin
                                do_fin = 1'b1;
                                fin_ph = tlssni_pkg::PH_CMSKIP;
                            end else begin
                                n_phase = tlssni_pkg::PH_CMSKIP;
                                n_skip  = v16;
                            end
                        end
                        tlssni_pkg::PH_EXL: begin
                            n_exts_end = end_sum;
                            if (25'(end_sum) > r_hs_end) begin
                                fail = 1'b1;
                            end else begin
                                do_head  = 1'b1;
                                head_end = end_sum;
                            end
                        end
                        tlssni_pkg::PH_EXH: begin
                            if (end_sum > r_exts_end) begin
                                fail = 1'b1;
                            end else if (w_nrem == tlssni_pkg::EXT_SERVER_NAME) begin
                                if (v16 < 16'd6) begin
                                    fail = 1'b1;
                                end else begin
                                    n_ext_end = end_sum;
                                    n_phase   = tlssni_pkg::PH_SN;
                                    n_skip    = 16'd5;
                                    n_acc     = '0;
                                end
                            end else if (v16 == 16'd0) begin
                                do_fin = 1'b1;
                                fin_ph = tlssni_pkg::PH_EXSKIP;
                            end else begin
                                n_phase = tlssni_pkg::PH_EXSKIP;
                                n_skip  = v16;
                            end
                        end
                        default: begin
                            // Server name list header: list length, name type, name length.
                            if (shifted[23:16] != tlssni_pkg::NAME_TYPE_HOST
                                || end_sum > r_ext_end) begin
                                fail = 1'b1;
                            end else begin
                                n_copied = '0;
                                if (emit == 16'd0) begin
                                    done = 1'b1;
                                end else begin
                                    n_nrem  = emit;
                                    n_phase = tlssni_pkg::PH_NAME;
                                end
                            end
                        end
                    endcase
                end
            end
            tlssni_pkg::PH_NAME: begin
                name_out = 1'b1;
                n_copied = cnt_inc;
                n_nrem   = nrem_dec;
                if (nrem_dec == 16'd0) begin
                    done     = 1'b1;
                    done_len = cnt_inc;
                end
            end
            default: begin
            end
        endcase

        if (do_fin) begin
            case (fin_ph)
                tlssni_pkg::PH_RAND: begin
                    n_phase = tlssni_pkg::PH_SID;
                    n_skip  = 16'd1;
                    n_acc   = '0;
                end
                tlssni_pkg::PH_SIDSKIP: begin
                    n_phase = tlssni_pkg::PH_CSL;
                    n_skip  = 16'd2;
                    n_acc   = '0;
                end
                tlssni_pkg::PH_CSSKIP: begin
                    n_phase = tlssni_pkg::PH_CML;
                    n_skip  = 16'd1;
                    n_acc   = '0;
                end
                tlssni_pkg::PH_CMSKIP: begin
                    n_phase = tlssni_pkg::PH_EXL;
                    n_skip  = 16'd2;
                    n_acc   = '0;
                end
                default: begin
                    do_head = 1'b1;
                end
            endcase
        end

        // Another extension header must fit inside the extension list.
        if (do_head) begin
            if (19'(next_pos) + 19'd4 > 19'(head_end)) begin
                fail = 1'b1;
            end else begin
                n_phase = tlssni_pkg::PH_EXH;
                n_skip  = 16'd4;
                n_acc   = '0;
            end
        end

        verdict = fail || done;
        if (verdict) begin
            n_phase = tlssni_pkg::PH_IDLE;
        end
        if (n_phase != tlssni_pkg::PH_IDLE) begin
            n_pos = w_pos + 17'd1;
        end

        res_cut.item_kind   = tlssni_pkg::ITEM_VERDICT;
        res_cut.name_byte   = '0;
        res_cut.found       = 1'b0;
        res_cut.name_length = '0;

        res_name.item_kind   = tlssni_pkg::ITEM_NAME;
        res_name.name_byte   = i_data_byte;
        res_name.found       = 1'b0;
        res_name.name_length = '0;

        res_proc.item_kind   = tlssni_pkg::ITEM_VERDICT;
        res_proc.name_byte   = '0;
        res_proc.found       = done;
        res_proc.name_length = done ? done_len : 8'd0;

        o_push.valid0 = i_accept && (cut || name_out || verdict);
        o_push.valid1 = i_accept && (cut || name_out) && verdict;
        o_push.slot0  = cut ? res_cut : (name_out ? res_name : res_proc);
        o_push.slot1  = res_proc;
    end

endmodule

@@ hdl/tls_client_hello_sni_extractor.sv @@
// Top level of the TLS ClientHello SNI extractor: channel handshakes and result queue.
// Depends on tlssni_pkg, tlssni_in_if / tlssni_out_if and tlssni_parser.
//
// The block takes one TCP payload byte per transaction on i_byte_ch. A transaction with
// first_flag set starts a new segment and samples segment_length. The block walks the TLS
// record and ClientHello headers and the extension list, and in the first server_name
// extension it sends each host name byte (cut to NAME_MAX_BYTES) as one transaction on
// o_result_ch, followed by a verdict transaction. Malformed, fragmented or non-SNI input
// gives a single not-found verdict on the byte that decides it; a segment cut short by a
// new first byte gets its not-found verdict before the new byte's own result.
// A byte is parsed in the cycle it is accepted and its results are written into a
// four-entry result queue that drives o_result_ch. One byte is accepted every cycle while
// the queue has room; a byte can cause two results, so the throughput then depends on the
// sink taking one result per cycle. The input is ready
// whenever the queue holds two results or fewer, so a stalled sink backs up the input
// once three or four results wait. Reset (synchronous, active low) empties the queue and
// returns the parser to idle; bytes that arrive before the first first_flag are ignored.

module tls_client_hello_sni_extractor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlssni_in_if.sink         i_byte_ch,
    tlssni_out_if.source      o_result_ch
);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    tlssni_pkg::t_push   push;
    tlssni_pkg::t_result r_fifo [FIFO_DEPTH];
    tlssni_pkg::t_result head;
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]      r_count, n_count;
    logic [PTR_W-1:0]    wr_ptr1;
    logic                in_accept;
    logic                out_pop;

    // Room for the worst case of two results per byte.
    assign i_byte_ch.ready = i_rst_n && (r_count <= (PTR_W + 1)'(FIFO_DEPTH - 2));
    assign in_accept       = i_byte_ch.valid && i_byte_ch.ready;

    tlssni_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_data_byte      (i_byte_ch.data_byte),
        .i_first_flag     (i_byte_ch.first_flag),
        .i_segment_length (i_byte_ch.segment_length),
        .o_push           (push)
    );

    // Result queue: up to two writes and one read per cycle.
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);
    assign out_pop = o_result_ch.valid && o_result_ch.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(push.valid0) + PTR_W'(push.valid1);
        n_rd_ptr = r_rd_ptr + PTR_W'(out_pop);
        n_count  = r_count + (PTR_W + 1)'(push.valid0) + (PTR_W + 1)'(push.valid1)
                   - (PTR_W + 1)'(out_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push.valid0) begin
            r_fifo[r_wr_ptr] <= push.slot0;
        end
        if (push.valid1) begin
            r_fifo[wr_ptr1] <= push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign head                    = r_fifo[r_rd_ptr];
    assign o_result_ch.valid       = (r_count != '0);
    assign o_result_ch.item_kind   = head.item_kind;
    assign o_result_ch.name_byte   = head.name_byte;
    assign o_result_ch.found       = head.found;
    assign o_result_ch.name_length = head.name_length;

    // The queue never holds more than its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A second result from one byte is always a verdict and never comes alone.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid1 |-> (push.valid0 && push.slot1.item_kind == tlssni_pkg::ITEM_VERDICT))
        else $error("second result of a byte is not a verdict");

    // A delivered result with nothing new written shrinks the queue by one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_pop && !push.valid0) |=> (r_count == $past(r_count) - (PTR_W + 1)'(1)))
        else $error("result queue count mismatch");

endmodule
